// ----- design/hsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and constants of the sensor frame decoder
// Holds the frame layout, the CRC-8 step, the scaling constants, the status
// codes and the job record that is passed from the byte parser to the scaler.
// ----------------------------------------------------------------------------
package hsfd_pkg;

    // Frame layout: byte positions within the six-byte response
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // CRC-8, polynomial 0x31, start 0xFF, MSB first, no final XOR
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TEMP_CRC = 2'd1;
    localparam logic [1:0] ST_HUM_CRC  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_TEMP_MIN = 1'b0;
    localparam logic CFG_TEMP_MAX = 1'b1;

    localparam int TEMP_W = 15;
    localparam int HUM_W  = 14;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_RESET = -15'sd4000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_RESET = 15'sd12500;

    // Scaling: value = floor(SPAN * raw / 65535), temperature minus offset
    localparam logic [30:0] TEMP_SPAN   = 31'd17500;
    localparam logic [29:0] HUM_SPAN    = 30'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // Depth of the job queue between parser and scaler
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] hum_raw;
        logic [1:0]  status;   // ST_OK or one of the CRC failure codes
    } hsfd_job_t;

    typedef struct packed {
        logic      valid;
        hsfd_job_t job;
    } hsfd_push_t;

    // Fold one byte into the running CRC, one bit per step
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/hsfd_front.sv -----
// ----------------------------------------------------------------------------
// hsfd_front: frame byte parser
// Tracks the byte position, runs the CRC over each word, holds the raw words
// and pushes one classified job per completed frame.
// ----------------------------------------------------------------------------
module hsfd_front
    import hsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_take,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    output hsfd_push_t push
);

    logic [2:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic        temp_bad_reg, temp_bad_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] hum_raw_reg, hum_raw_next;
    logic [7:0]  crc_folded;

    // Restart on frame_start or an unreachable position
    assign pos_eff    = (frame_start || pos_reg > POS_HUM_CRC) ? POS_TEMP_HI : pos_reg;
    assign crc_folded = crc8_fold((pos_eff == POS_TEMP_HI) ? CRC_INIT : crc_reg, rx_byte);

    always_comb begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_bad_next  = temp_bad_reg;
        temp_word_next = temp_word_reg;
        hum_raw_next   = hum_raw_reg;
        push           = '0;
        if (byte_take) begin
            unique case (pos_eff)
                POS_TEMP_HI: begin
                    crc_next       = crc_folded;
                    temp_word_next = {rx_byte, 8'h00};
                    pos_next       = POS_TEMP_LO;
                end
                POS_TEMP_LO: begin
                    crc_next       = crc_folded;
                    temp_word_next = {temp_word_reg[15:8], rx_byte};
                    pos_next       = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    temp_bad_next = (crc_reg != rx_byte);
                    crc_next      = CRC_INIT;
                    pos_next      = POS_HUM_HI;
                end
                POS_HUM_HI: begin
                    crc_next     = crc_folded;
                    hum_raw_next = {rx_byte, 8'h00};
                    pos_next     = POS_HUM_LO;
                end
                POS_HUM_LO: begin
                    crc_next     = crc_folded;
                    hum_raw_next = {hum_raw_reg[15:8], rx_byte};
                    pos_next     = POS_HUM_CRC;
                end
                default: begin
                    // Humidity CRC byte: classify and hand the frame on
                    push.valid         = 1'b1;
                    push.job.temp_word = temp_word_reg;
                    push.job.hum_raw   = hum_raw_reg;
                    if (temp_bad_reg) begin
                        push.job.status = ST_TEMP_CRC;
                    end else if (crc_reg != rx_byte) begin
                        push.job.status = ST_HUM_CRC;
                    end else begin
                        push.job.status = ST_OK;
                    end
                    pos_next      = POS_TEMP_HI;
                    crc_next      = CRC_INIT;
                    temp_bad_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= POS_TEMP_HI;
            crc_reg      <= CRC_INIT;
            temp_bad_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            temp_bad_reg <= temp_bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_word_reg <= temp_word_next;
        hum_raw_reg   <= hum_raw_next;
    end

endmodule

// ----- design/hsfd_queue.sv -----
// ----------------------------------------------------------------------------
// hsfd_queue: job queue
// Short FIFO of classified frames between the parser and the scaler.
// ----------------------------------------------------------------------------
module hsfd_queue
    import hsfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  hsfd_push_t push,
    output logic       full,
    output logic       pop_valid,
    input  logic       pop_ready,
    output hsfd_job_t  pop_job
);

    hsfd_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Advance a pointer with wrap at the queue depth
    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// ----- design/hsfd_back.sv -----
// ----------------------------------------------------------------------------
// hsfd_back: value scaler and result register
// Three-stage pipeline: multiply, divide by 65535, range check into the
// output register. The whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
module hsfd_back
    import hsfd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  hsfd_job_t                job,
    input  logic signed [TEMP_W-1:0] temp_min,
    input  logic signed [TEMP_W-1:0] temp_max,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temp_centi,
    output logic [HUM_W-1:0]         m_hum_centi,
    output logic [1:0]               m_status
);

    logic                     adv;
    logic                     s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [30:0]              s1_temp_prod_reg;
    logic [29:0]              s1_hum_prod_reg;
    logic [1:0]               s1_status_reg, s2_status_reg, out_status_reg;
    logic signed [TEMP_W-1:0] s2_temp_reg, s2_temp_next, out_temp_reg, out_temp_next;
    logic [HUM_W-1:0]         s2_hum_reg, s2_hum_next, out_hum_reg, out_hum_next;
    logic [1:0]               out_status_next;
    logic [14:0]              temp_q;
    logic [13:0]              hum_q;
    logic [16:0]              temp_sum, hum_sum;
    logic [15:0]              temp_quot;
    logic [15:0]              temp_shift;

    assign adv       = !out_valid_reg || m_ready;
    assign job_ready = adv;

    // x / 65535 = q + (q + r >= 65535), with q = x >> 16 and r = x & 0xFFFF
    always_comb begin
        temp_q       = s1_temp_prod_reg[30:16];
        temp_sum     = {2'b00, temp_q} + {1'b0, s1_temp_prod_reg[15:0]};
        temp_quot    = {1'b0, temp_q} + 16'((temp_sum >= FULL_SCALE) ? 1 : 0);
        temp_shift   = temp_quot - TEMP_OFFSET;
        s2_temp_next = $signed(temp_shift[TEMP_W-1:0]);

        hum_q       = s1_hum_prod_reg[29:16];
        hum_sum     = {3'b000, hum_q} + {1'b0, s1_hum_prod_reg[15:0]};
        s2_hum_next = hum_q + HUM_W'((hum_sum >= FULL_SCALE) ? 1 : 0);
    end

    // Zero the values on CRC failure, flag out-of-range temperature
    always_comb begin
        if (s2_status_reg != ST_OK) begin
            out_temp_next   = '0;
            out_hum_next    = '0;
            out_status_next = s2_status_reg;
        end else begin
            out_temp_next   = s2_temp_reg;
            out_hum_next    = s2_hum_reg;
            out_status_next = (s2_temp_reg >= temp_min && s2_temp_reg <= temp_max)
                              ? ST_OK : ST_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_temp_prod_reg <= 31'(job.temp_word) * TEMP_SPAN;
            s1_hum_prod_reg  <= 30'(job.hum_raw) * HUM_SPAN;
            s1_status_reg    <= job.status;
            s2_temp_reg      <= s2_temp_next;
            s2_hum_reg       <= s2_hum_next;
            s2_status_reg    <= s1_status_reg;
            out_temp_reg     <= out_temp_next;
            out_hum_reg      <= out_hum_next;
            out_status_reg   <= out_status_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_temp_centi = out_temp_reg;
    assign m_hum_centi  = out_hum_reg;
    assign m_status     = out_status_reg;

endmodule

// ----- design/humidity_sensor_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder_core: temperature/humidity frame decoder
// Checks the two CRC-8 words of a six-byte sensor response and converts the
// raw words to centidegrees and centipercent with a status code.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (s_valid/s_ready): one frame byte per transfer, in order
//    temp hi, temp lo, temp CRC, hum hi, hum lo, hum CRC. s_frame_start
//    marks a byte as the first of a frame and drops any partial frame.
//  - Result channel (m_valid/m_ready): one transfer per complete frame with
//    temperature, humidity and status (0 ok, 1 temp CRC, 2 hum CRC, 3 range).
//  - Config port: cfg_we writes cfg_wdata to the limit register at cfg_index
//    (0 minimum, 1 maximum temperature); write only while idle.
//  - Throughput: one byte per cycle while s_ready is high, set by the CRC
//    step of the parser; hence one result per six bytes at most.
//  - Result path: after the sixth byte's transfer the frame passes the queue
//    write, multiply stage, divide stage and range check into the output.
//  - Stall: while a result waits with m_ready low the scaler holds; the job
//    queue takes up to two more frames, then s_ready drops until it has room.
//  - Reset: synchronous, active low; clears the byte position, CRC, queue
//    and pipeline, and loads the limits with -4000 and 12500.
// ----------------------------------------------------------------------------
module humidity_sensor_frame_decoder_core
    import hsfd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // Byte input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_rx_byte,
    input  logic                     s_frame_start,
    // Result output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temp_centi,
    output logic [HUM_W-1:0]         m_hum_centi,
    output logic [1:0]               m_status,
    // Configuration writes
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [TEMP_W-1:0]        cfg_wdata
);

    logic signed [TEMP_W-1:0] temp_min_reg, temp_min_next;
    logic signed [TEMP_W-1:0] temp_max_reg, temp_max_next;
    hsfd_push_t               push;
    logic                     queue_full;
    logic                     job_valid, job_ready;
    hsfd_job_t                job;
    logic                     byte_take;

    // Accept a byte whenever the queue can take a finished frame
    assign s_ready   = !queue_full;
    assign byte_take = s_valid && s_ready;

    // Limit registers
    always_comb begin
        temp_min_next = temp_min_reg;
        temp_max_next = temp_max_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEMP_MIN: temp_min_next = $signed(cfg_wdata);
                CFG_TEMP_MAX: temp_max_next = $signed(cfg_wdata);
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_min_reg <= TEMP_MIN_RESET;
            temp_max_reg <= TEMP_MAX_RESET;
        end else begin
            temp_min_reg <= temp_min_next;
            temp_max_reg <= temp_max_next;
        end
    end

    // Front: parse bytes, check CRCs, classify frames
    hsfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_take   (byte_take),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .push        (push)
    );

    // Decouple parser from scaler
    hsfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (queue_full),
        .pop_valid (job_valid),
        .pop_ready (job_ready),
        .pop_job   (job)
    );

    // Back: scale, range check, hold the result
    hsfd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .temp_min     (temp_min_reg),
        .temp_max     (temp_max_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_temp_centi (m_temp_centi),
        .m_hum_centi  (m_hum_centi),
        .m_status     (m_status)
    );

endmodule
